@@ hdl/fcgf_pkg.sv @@
// shared constants, types and helper functions of the frontier goal finder
package fcgf_pkg;

  localparam int GRID_W   = 64;
  localparam int GRID_H   = 64;
  localparam int MAX_REJ  = 8;
  localparam int CELLS    = GRID_W * GRID_H;
  localparam int CW       = 6;
  localparam int CSW      = CW + 2;
  localparam int IW       = $clog2(CELLS);
  localparam int NW       = IW + 1;
  localparam int SUM_W    = NW + CW - 1;
  localparam int D2W      = 2 * CW + 1;
  localparam int RIW      = $clog2(MAX_REJ);
  localparam int RCW      = RIW + 1;
  localparam int NB_CNT   = 9;
  localparam int NB_CTR   = 4;

  localparam logic [1:0] ST_UNKNOWN  = 2'd0;
  localparam logic [1:0] ST_FREE     = 2'd1;
  localparam logic [1:0] ST_OCCUPIED = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  localparam logic [1:0] MODE_CELL   = 2'd0;
  localparam logic [1:0] MODE_REJ    = 2'd1;
  localparam logic [1:0] MODE_SEARCH = 2'd2;

  localparam logic [2:0] REG_RADIUS   = 3'd0;
  localparam logic [2:0] REG_MIN_SIZE = 3'd1;
  localparam logic [2:0] REG_MIN_UNK  = 3'd2;
  localparam logic [2:0] REG_MIN_FREE = 3'd3;
  localparam logic [2:0] REG_MAX_OCC  = 3'd4;

  typedef struct packed {
    logic [7:0]  radius;
    logic [12:0] min_size;
    logic [3:0]  min_unk;
    logic [3:0]  min_free;
    logic [3:0]  max_occ;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_WRITE_IN, OP_START, OP_CLR, OP_SEED_RD, OP_FC_INIT, OP_FC_STEP,
    OP_SEED_PUSH, OP_POP_RD, OP_POP_TAKE, OP_NB_RD, OP_NB_NEXT, OP_NB_PUSH,
    OP_DIV_INIT, OP_DIV_STEP, OP_SCAN_RD, OP_SCAN_CMP, OP_REJ_STEP, OP_BEST,
    OP_SEED_NEXT, OP_LOAD_OUT, OP_GCLR
  } dp_op_t;

  typedef struct packed {
    logic clr_last;
    logic vis_hit;
    logic fc_last;
    logic frontier;
    logic stk_empty;
    logic nb_end;
    logic nb_skip;
    logic too_small;
    logic div_last;
    logic scan_last;
    logic rej_more;
    logic seed_last;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_SEED_RD, S_SEED_CHK, S_FC_STEP, S_FC_EVAL, S_POP,
    S_POP_TAKE, S_NB_RD, S_NB_CHK, S_SIZE, S_DIV, S_SCAN_RD, S_SCAN_CMP,
    S_REJ, S_BEST, S_SEED_NEXT, S_DONE, S_GCLR
  } st_t;

  function automatic logic [D2W-1:0] sqd(logic [CW-1:0] ax, logic [CW-1:0] ay,
                                         logic [CW-1:0] bx, logic [CW-1:0] by);
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    ex = (ax > bx) ? ax - bx : bx - ax;
    ey = (ay > by) ? ay - by : by - ay;
    return D2W'(ex) * D2W'(ex) + D2W'(ey) * D2W'(ey);
  endfunction

  // neighbour order: dx outer, dy inner, both -1..1
  function automatic logic signed [1:0] nb_dx(logic [3:0] k);
    case (k)
      4'd0, 4'd1, 4'd2: return -2'sd1;
      4'd3, 4'd4, 4'd5: return 2'sd0;
      default:          return 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] nb_dy(logic [3:0] k);
    case (k)
      4'd0, 4'd3, 4'd6: return -2'sd1;
      4'd1, 4'd4, 4'd7: return 2'sd0;
      default:          return 2'sd1;
    endcase
  endfunction

  function automatic logic signed [CSW-1:0] step_coord(logic [CW-1:0] c,
                                                       logic signed [1:0] d);
    return $signed({2'b00, c}) + CSW'(d);
  endfunction

  function automatic logic [IW-1:0] cell_idx(logic [CW-1:0] x, logic [CW-1:0] y);
    return IW'(x) * IW'(GRID_H) + IW'(y);
  endfunction

endpackage

@@ hdl/fcgf_ram.sv @@
// generic single-write, single-read memory with registered read data
module fcgf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/fcgf_dp.sv @@
// datapath: grid, visited, stack and member memories, counters and arithmetic
module fcgf_dp import fcgf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  dp_op_t          op,
  input  cfg_t            cfg,
  input  logic [1:0]      mode_in,
  input  logic [CW-1:0]   x_in,
  input  logic [CW-1:0]   y_in,
  input  logic [1:0]      cs_in,
  input  logic [2:0]      slot_in,
  input  logic [3:0]      act_in,
  input  logic            out_tready,
  output logic            out_tvalid,
  output logic            out_found,
  output logic [CW-1:0]   out_x,
  output logic [CW-1:0]   out_y,
  output logic [12:0]     out_size,
  output dp_stat_t        stat
);

  logic [CW-1:0]    rob_x_r, rob_y_r;
  logic [RCW-1:0]   nrej_r;
  logic [15:0]      r2_r;
  logic [IW-1:0]    clr_r;
  logic [CW-1:0]    seed_x_r, seed_y_r;
  logic [CW-1:0]    cand_x_r, cand_y_r;
  logic [3:0]       fc_k_r, pend_pos_r;
  logic             pend_vld_r, ctr_free_r;
  logic [3:0]       nu_r, nf_r, no_r;
  logic [NW-1:0]    sp_r, n_r;
  logic [SUM_W-1:0] sumx_r, sumy_r;
  logic [CW-1:0]    cur_x_r, cur_y_r;
  logic [3:0]       nb_j_r;
  logic [SUM_W-1:0] dvx_r, dvy_r, qx_r, qy_r;
  logic [NW-1:0]    remx_r, remy_r;
  logic [4:0]       dcnt_r;
  logic [NW-1:0]    i_r;
  logic [D2W-1:0]   td_r;
  logic [CW-1:0]    tx_r, ty_r;
  logic [RCW-1:0]   r_r;
  logic             rej_hit_r;
  logic             found_r;
  logic [NW-1:0]    best_size_r;
  logic [D2W-1:0]   best_d_r;
  logic [CW-1:0]    gx_r, gy_r;
  logic             out_vld_r, out_found_r;
  logic [CW-1:0]    out_x_r, out_y_r;
  logic [12:0]      out_size_r;
  logic [CW-1:0]    rej_x_r [MAX_REJ];
  logic [CW-1:0]    rej_y_r [MAX_REJ];

  logic             g_we;
  logic [IW-1:0]    g_waddr;
  logic [1:0]       g_wd;
  logic [IW-1:0]    g_raddr;
  logic [1:0]       g_rd;
  logic             v_we, v_wd;
  logic [IW-1:0]    v_waddr, v_raddr;
  logic [0:0]       v_rd;
  logic             s_we;
  logic [IW-1:0]    s_waddr;
  logic [IW-1:0]    s_rd;
  logic [IW-1:0]    m_rd;
  logic [NW-1:0]    sp_m1;

  logic signed [CSW-1:0] fc_nx, fc_ny, nb_nx, nb_ny;
  logic             fc_inmap, nb_inmap;
  logic [CW-1:0]    pop_x, pop_y, mem_x, mem_y;
  logic [NW:0]      rsx, rsy;
  logic             bx, by;
  logic [D2W-1:0]   scan_d, rej_d, rob_d;

  assign fc_nx = step_coord(cand_x_r, nb_dx(fc_k_r));
  assign fc_ny = step_coord(cand_y_r, nb_dy(fc_k_r));
  assign fc_inmap = !fc_nx[CSW-1] && !fc_ny[CSW-1] &&
                    fc_nx < CSW'(GRID_W) && fc_ny < CSW'(GRID_H);
  assign nb_nx = step_coord(cur_x_r, nb_dx(nb_j_r));
  assign nb_ny = step_coord(cur_y_r, nb_dy(nb_j_r));
  assign nb_inmap = !nb_nx[CSW-1] && !nb_ny[CSW-1] &&
                    nb_nx < CSW'(GRID_W) && nb_ny < CSW'(GRID_H);

  assign sp_m1 = sp_r - NW'(1);
  assign pop_x = CW'(s_rd / GRID_H);
  assign pop_y = CW'(s_rd % GRID_H);
  assign mem_x = CW'(m_rd / GRID_H);
  assign mem_y = CW'(m_rd % GRID_H);

  // one restoring division bit per step for both centroid axes
  assign rsx = {remx_r, dvx_r[SUM_W-1]};
  assign rsy = {remy_r, dvy_r[SUM_W-1]};
  assign bx  = rsx >= {1'b0, n_r};
  assign by  = rsy >= {1'b0, n_r};

  assign scan_d = sqd(mem_x, mem_y, qx_r[CW-1:0], qy_r[CW-1:0]);
  assign rej_d  = sqd(tx_r, ty_r, rej_x_r[r_r[RIW-1:0]], rej_y_r[r_r[RIW-1:0]]);
  assign rob_d  = sqd(tx_r, ty_r, rob_x_r, rob_y_r);

  always_comb begin
    g_we    = (op == OP_WRITE_IN) && (mode_in == MODE_CELL) && (cs_in != ST_BAD) &&
              (int'(x_in) < GRID_W) && (int'(y_in) < GRID_H);
    g_waddr = cell_idx(x_in, y_in);
    g_wd    = cs_in;
    g_raddr = cell_idx(fc_nx[CW-1:0], fc_ny[CW-1:0]);
    v_we    = 1'b0;
    v_wd    = 1'b0;
    v_waddr = cell_idx(cand_x_r, cand_y_r);
    v_raddr = cell_idx(seed_x_r, seed_y_r);
    s_we    = 1'b0;
    s_waddr = sp_r[IW-1:0];
    case (op)
      OP_GCLR: begin
        g_we    = 1'b1;
        g_waddr = clr_r;
        g_wd    = ST_UNKNOWN;
      end
      OP_CLR: begin
        v_we    = 1'b1;
        v_waddr = clr_r;
      end
      OP_SEED_PUSH: begin
        v_we    = 1'b1;
        v_wd    = 1'b1;
        s_we    = 1'b1;
        s_waddr = '0;
      end
      OP_NB_PUSH: begin
        v_we = 1'b1;
        v_wd = 1'b1;
        s_we = 1'b1;
      end
      OP_NB_RD: begin
        v_raddr = cell_idx(nb_nx[CW-1:0], nb_ny[CW-1:0]);
      end
      default: ;
    endcase
  end

  fcgf_ram #(.WIDTH(2), .DEPTH(CELLS)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wd),
    .raddr(g_raddr), .rdata(g_rd)
  );

  fcgf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wd),
    .raddr(v_raddr), .rdata(v_rd)
  );

  fcgf_ram #(.WIDTH(IW), .DEPTH(CELLS)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(cell_idx(cand_x_r, cand_y_r)),
    .raddr(sp_m1[IW-1:0]), .rdata(s_rd)
  );

  fcgf_ram #(.WIDTH(IW), .DEPTH(CELLS)) u_members (
    .clk(clk), .we(op == OP_POP_TAKE), .waddr(n_r[IW-1:0]), .wdata(s_rd),
    .raddr(i_r[IW-1:0]), .rdata(m_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (op == OP_LOAD_OUT) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      case (op)
        OP_WRITE_IN: begin
          if (mode_in == MODE_REJ && int'(slot_in) < MAX_REJ) begin
            rej_x_r[slot_in[RIW-1:0]] <= x_in;
            rej_y_r[slot_in[RIW-1:0]] <= y_in;
          end
        end
        OP_START: begin
          rob_x_r     <= x_in;
          rob_y_r     <= y_in;
          nrej_r      <= (int'(act_in) > MAX_REJ) ? RCW'(MAX_REJ) : RCW'(act_in);
          r2_r        <= 16'(cfg.radius) * 16'(cfg.radius);
          clr_r       <= '0;
          seed_x_r    <= '0;
          seed_y_r    <= '0;
          found_r     <= 1'b0;
          best_size_r <= '0;
          best_d_r    <= '0;
          gx_r        <= '0;
          gy_r        <= '0;
        end
        OP_CLR, OP_GCLR: clr_r <= clr_r + IW'(1);
        OP_SEED_RD: begin
          cand_x_r <= seed_x_r;
          cand_y_r <= seed_y_r;
        end
        OP_FC_INIT: begin
          fc_k_r     <= '0;
          nu_r       <= '0;
          nf_r       <= '0;
          no_r       <= '0;
          ctr_free_r <= 1'b0;
        end
        OP_FC_STEP: begin
          fc_k_r     <= fc_k_r + 4'd1;
          pend_pos_r <= fc_k_r;
          pend_vld_r <= fc_inmap;
          if (fc_k_r != 4'd0) begin
            if (pend_pos_r == 4'(NB_CTR)) begin
              ctr_free_r <= (g_rd == ST_FREE);
            end else if (pend_vld_r) begin
              case (g_rd)
                ST_UNKNOWN:  nu_r <= nu_r + 4'd1;
                ST_FREE:     nf_r <= nf_r + 4'd1;
                ST_OCCUPIED: no_r <= no_r + 4'd1;
                default: ;
              endcase
            end
          end
        end
        OP_SEED_PUSH: begin
          sp_r   <= NW'(1);
          n_r    <= '0;
          sumx_r <= '0;
          sumy_r <= '0;
        end
        OP_POP_RD: sp_r <= sp_m1;
        OP_POP_TAKE: begin
          cur_x_r <= pop_x;
          cur_y_r <= pop_y;
          n_r     <= n_r + NW'(1);
          sumx_r  <= sumx_r + SUM_W'(pop_x);
          sumy_r  <= sumy_r + SUM_W'(pop_y);
          nb_j_r  <= '0;
        end
        OP_NB_RD: begin
          cand_x_r <= nb_nx[CW-1:0];
          cand_y_r <= nb_ny[CW-1:0];
        end
        OP_NB_NEXT: nb_j_r <= nb_j_r + 4'd1;
        OP_NB_PUSH: begin
          sp_r   <= sp_r + NW'(1);
          nb_j_r <= nb_j_r + 4'd1;
        end
        OP_DIV_INIT: begin
          dvx_r     <= sumx_r;
          dvy_r     <= sumy_r;
          remx_r    <= '0;
          remy_r    <= '0;
          dcnt_r    <= '0;
          i_r       <= '0;
          r_r       <= '0;
          rej_hit_r <= 1'b0;
        end
        OP_DIV_STEP: begin
          dvx_r  <= dvx_r << 1;
          dvy_r  <= dvy_r << 1;
          remx_r <= bx ? NW'(rsx - {1'b0, n_r}) : NW'(rsx);
          remy_r <= by ? NW'(rsy - {1'b0, n_r}) : NW'(rsy);
          qx_r   <= {qx_r[SUM_W-2:0], bx};
          qy_r   <= {qy_r[SUM_W-2:0], by};
          dcnt_r <= dcnt_r + 5'd1;
        end
        OP_SCAN_CMP: begin
          if (i_r == '0 || scan_d < td_r) begin
            td_r <= scan_d;
            tx_r <= mem_x;
            ty_r <= mem_y;
          end
          i_r <= i_r + NW'(1);
        end
        OP_REJ_STEP: begin
          if (16'(rej_d) <= r2_r) begin
            rej_hit_r <= 1'b1;
          end
          r_r <= r_r + RCW'(1);
        end
        OP_BEST: begin
          if (!rej_hit_r && (!found_r || n_r > best_size_r ||
              (n_r == best_size_r && rob_d < best_d_r))) begin
            found_r     <= 1'b1;
            best_size_r <= n_r;
            best_d_r    <= rob_d;
            gx_r        <= tx_r;
            gy_r        <= ty_r;
          end
        end
        OP_SEED_NEXT: begin
          seed_y_r <= (int'(seed_y_r) == GRID_H - 1) ? '0 : seed_y_r + CW'(1);
          if (int'(seed_y_r) == GRID_H - 1) begin
            seed_x_r <= seed_x_r + CW'(1);
          end
        end
        OP_LOAD_OUT: begin
          out_found_r <= found_r;
          out_x_r     <= gx_r;
          out_y_r     <= gy_r;
          out_size_r  <= 13'(best_size_r);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.clr_last  = (clr_r == IW'(CELLS - 1));
    stat.vis_hit   = v_rd[0];
    stat.fc_last   = (fc_k_r == 4'(NB_CNT));
    stat.frontier  = ctr_free_r && (nu_r >= cfg.min_unk) && (nf_r >= cfg.min_free) &&
                     (no_r <= cfg.max_occ);
    stat.stk_empty = (sp_r == '0);
    stat.nb_end    = (nb_j_r == 4'(NB_CNT));
    stat.nb_skip   = (nb_j_r == 4'(NB_CTR)) || !nb_inmap;
    stat.too_small = (n_r < cfg.min_size);
    stat.div_last  = (dcnt_r == 5'(SUM_W - 1));
    stat.scan_last = (i_r == n_r - NW'(1));
    stat.rej_more  = (r_r < nrej_r);
    stat.seed_last = (int'(seed_x_r) == GRID_W - 1) && (int'(seed_y_r) == GRID_H - 1);
    stat.out_busy  = out_vld_r;
  end

  assign out_tvalid = out_vld_r;
  assign out_found  = out_found_r;
  assign out_x      = out_x_r;
  assign out_y      = out_y_r;
  assign out_size   = out_size_r;

endmodule

@@ hdl/fcgf_ctrl.sv @@
// controller: sequences writes, visited clearing, seed scan, fill and cluster scoring
module fcgf_ctrl import fcgf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic [1:0] in_mode,
  input  logic       out_tready,
  input  dp_stat_t   stat,
  output logic       in_tready,
  output dp_op_t     op
);

  st_t  st_r, st_nxt;
  logic nb_ctx_r, nb_ctx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_GCLR;
      nb_ctx_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      nb_ctx_r <= nb_ctx_nxt;
    end
  end

  always_comb begin
    st_nxt     = st_r;
    nb_ctx_nxt = nb_ctx_r;
    op         = OP_NONE;
    in_tready  = 1'b0;
    case (st_r)
      S_GCLR: begin
        // fill the grid with unknown after reset
        op = OP_GCLR;
        if (stat.clr_last) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_mode == MODE_SEARCH) begin
            op     = OP_START;
            st_nxt = S_CLR;
          end else begin
            op = OP_WRITE_IN;
          end
        end
      end
      S_CLR: begin
        op = OP_CLR;
        if (stat.clr_last) st_nxt = S_SEED_RD;
      end
      S_SEED_RD: begin
        op     = OP_SEED_RD;
        st_nxt = S_SEED_CHK;
      end
      S_SEED_CHK: begin
        if (stat.vis_hit) begin
          st_nxt = S_SEED_NEXT;
        end else begin
          op         = OP_FC_INIT;
          nb_ctx_nxt = 1'b0;
          st_nxt     = S_FC_STEP;
        end
      end
      S_FC_STEP: begin
        op = OP_FC_STEP;
        if (stat.fc_last) st_nxt = S_FC_EVAL;
      end
      S_FC_EVAL: begin
        if (nb_ctx_r) begin
          op     = stat.frontier ? OP_NB_PUSH : OP_NB_NEXT;
          st_nxt = S_NB_RD;
        end else if (stat.frontier) begin
          op     = OP_SEED_PUSH;
          st_nxt = S_POP;
        end else begin
          st_nxt = S_SEED_NEXT;
        end
      end
      S_POP: begin
        if (stat.stk_empty) begin
          st_nxt = S_SIZE;
        end else begin
          op     = OP_POP_RD;
          st_nxt = S_POP_TAKE;
        end
      end
      S_POP_TAKE: begin
        op     = OP_POP_TAKE;
        st_nxt = S_NB_RD;
      end
      S_NB_RD: begin
        if (stat.nb_end) begin
          st_nxt = S_POP;
        end else if (stat.nb_skip) begin
          op = OP_NB_NEXT;
        end else begin
          op     = OP_NB_RD;
          st_nxt = S_NB_CHK;
        end
      end
      S_NB_CHK: begin
        if (stat.vis_hit) begin
          op     = OP_NB_NEXT;
          st_nxt = S_NB_RD;
        end else begin
          op         = OP_FC_INIT;
          nb_ctx_nxt = 1'b1;
          st_nxt     = S_FC_STEP;
        end
      end
      S_SIZE: begin
        if (stat.too_small) begin
          st_nxt = S_SEED_NEXT;
        end else begin
          op     = OP_DIV_INIT;
          st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        op = OP_DIV_STEP;
        if (stat.div_last) st_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        op     = OP_SCAN_RD;
        st_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        op     = OP_SCAN_CMP;
        st_nxt = stat.scan_last ? S_REJ : S_SCAN_RD;
      end
      S_REJ: begin
        if (stat.rej_more) begin
          op = OP_REJ_STEP;
        end else begin
          st_nxt = S_BEST;
        end
      end
      S_BEST: begin
        op     = OP_BEST;
        st_nxt = S_SEED_NEXT;
      end
      S_SEED_NEXT: begin
        op     = OP_SEED_NEXT;
        st_nxt = stat.seed_last ? S_DONE : S_SEED_RD;
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!stat.out_busy || out_tready) begin
          op     = OP_LOAD_OUT;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hdl/frontier_cluster_goal_finder_unit.sv @@
// frontier cluster goal finder: top level with register file, controller and datapath
// grid and reject-point writes are taken at one transfer per cycle while the unit is idle.
// a search: clear the visited memory, then read and check each seed, with a frontier check
// if unvisited; per member a pop and in-map neighbour checks, frontier checks if unvisited;
// a kept cluster adds the divide, a member scan and reject checks; then the output register
// rst_n is synchronous; registers take defaults, then the grid is filled with unknown
module frontier_cluster_goal_finder_unit import fcgf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // x_coord, y_coord, cell_state, reject_slot, active_rejects
  input  logic [1:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // goal_x, goal_y, goal_size
  output logic [0:0]  out_tuser,  // found
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg_r;
  dp_op_t      op;
  dp_stat_t    stat;
  logic [2:0]  reg_idx;
  logic        out_found;
  logic [CW-1:0] out_x, out_y;
  logic [12:0] out_size;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius   <= 8'd0;
      cfg_r.min_size <= 13'd5;
      cfg_r.min_unk  <= 4'd2;
      cfg_r.min_free <= 4'd2;
      cfg_r.max_occ  <= 4'd0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_RADIUS:   cfg_r.radius   <= pwdata[7:0];
        REG_MIN_SIZE: cfg_r.min_size <= pwdata[12:0];
        REG_MIN_UNK:  cfg_r.min_unk  <= pwdata[3:0];
        REG_MIN_FREE: cfg_r.min_free <= pwdata[3:0];
        REG_MAX_OCC:  cfg_r.max_occ  <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RADIUS:   prdata = 32'(cfg_r.radius);
      REG_MIN_SIZE: prdata = 32'(cfg_r.min_size);
      REG_MIN_UNK:  prdata = 32'(cfg_r.min_unk);
      REG_MIN_FREE: prdata = 32'(cfg_r.min_free);
      REG_MAX_OCC:  prdata = 32'(cfg_r.max_occ);
      default:      prdata = '0;
    endcase
  end

  fcgf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_mode(in_tuser),
    .out_tready(out_tready), .stat(stat), .in_tready(in_tready), .op(op)
  );

  fcgf_dp u_dp (
    .clk(clk), .rst_n(rst_n), .op(op), .cfg(cfg_r), .mode_in(in_tuser),
    .x_in(in_tdata[5:0]), .y_in(in_tdata[11:6]), .cs_in(in_tdata[13:12]),
    .slot_in(in_tdata[16:14]), .act_in(in_tdata[20:17]), .out_tready(out_tready),
    .out_tvalid(out_tvalid), .out_found(out_found), .out_x(out_x), .out_y(out_y),
    .out_size(out_size), .stat(stat)
  );

  assign out_tdata = {7'd0, out_size, out_y, out_x};
  assign out_tuser = out_found;

endmodule
